// ===== hw/rtl/smcdp_pkg.sv =====
// ----------------------------------------------------------------------------
// smcdp_pkg
// Shared widths, defaults and register codes for the segment matching
// minimum cost dynamic programming block.
// ----------------------------------------------------------------------------
`default_nettype none

package smcdp_pkg;

    // Fixed field widths of the item channels.
    localparam int COST_W      = 32;
    localparam int END_W       = 11;
    localparam int TOTAL_W     = 32;
    localparam int TGT_OUT_W   = 12;
    localparam int START_OUT_W = 10;

    // Configuration register widths and port shape.
    localparam int CFG_MIN_W  = 11;
    localparam int CFG_SEQ_W  = 11;
    localparam int CFG_TGT_W  = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    // Register values after reset.
    localparam logic [CFG_MIN_W-1:0] CFG_MIN_RST = 11'd1;
    localparam logic [CFG_SEQ_W-1:0] CFG_SEQ_RST = 11'd1024;
    localparam logic [CFG_TGT_W-1:0] CFG_TGT_RST = 13'd1;

    // Default sizing of the block.
    localparam int DEF_MAX_FRAMES  = 1024;
    localparam int DEF_MAX_TARGETS = 4096;
    localparam int DEF_COST_BITS   = 32;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_LEN      = 2'd0,
        CFG_SEQ_LEN      = 2'd1,
        CFG_TARGET_COUNT = 2'd2
    } t_cfg_idx;

endpackage

`default_nettype wire

// ===== hw/rtl/smcdp_cost_if.sv =====
// ----------------------------------------------------------------------------
// smcdp_cost_if
// Valid/ready channel that carries one segment cost per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface smcdp_cost_if;
    logic                          valid;
    logic                          ready;
    logic [smcdp_pkg::COST_W-1:0]  seg_cost;

    modport source (output valid, output seg_cost, input ready);
    modport sink   (input valid, input seg_cost, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/smcdp_res_if.sv =====
// ----------------------------------------------------------------------------
// smcdp_res_if
// Valid/ready channel that carries one finished end frame per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface smcdp_res_if;
    logic                               valid;
    logic                               ready;
    logic [smcdp_pkg::END_W-1:0]        end_frame;
    logic [smcdp_pkg::TOTAL_W-1:0]      best_total;
    logic [smcdp_pkg::TGT_OUT_W-1:0]    best_target;
    logic [smcdp_pkg::START_OUT_W-1:0]  best_start;
    logic                               last;

    modport source (output valid, output end_frame, output best_total,
                    output best_target, output best_start, output last,
                    input ready);
    modport sink   (input valid, input end_frame, input best_total,
                    input best_target, input best_start, input last,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/segment_match_min_cost_dp.sv =====
// ----------------------------------------------------------------------------
// segment_match_min_cost_dp
// Minimum cost segmentation over a stream of segment costs, with the best
// totals per end frame kept in an on-chip memory.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake          Contents
//  --------  ---  -----------------  ------------------------------------------
//  i_cost    in   valid/ready        seg_cost, one cost per item
//  o_res     out  valid/ready        end_frame, best_total, best_target,
//                                    best_start, last
//  i_cfg_*   in   write enable only  min_len, seq_len, target_count
//
//  The block takes one cost item per cycle. An item is accepted in the cycle
//  its start frame reads the total memory; the registered stage after it
//  does the add, the saturation and the compare against the running minimum,
//  and the result of a finished end frame moves from that stage into the
//  output register. The single memory read port and the running minimum
//  loop set this rate.
//  Input stalls only when a finished result cannot move into the output
//  register, and in the cycle after a register write while the counters
//  reload. Reset is synchronous and active low; the memory has no clearing
//  pass because an entry is only read after this run has written it.
//
//  A start frame is read in the accept cycle; an end frame's total is written
//  as the second stage hands the frame to the output register. The next item
//  after an end frame always starts at start frame zero, which comes from a
//  constant, so no read ever overlaps a pending write of the same entry.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_match_min_cost_dp #(
    parameter int MAX_FRAMES  = smcdp_pkg::DEF_MAX_FRAMES,
    parameter int MAX_TARGETS = smcdp_pkg::DEF_MAX_TARGETS,
    parameter int COST_BITS   = smcdp_pkg::DEF_COST_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [smcdp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [smcdp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    smcdp_cost_if.sink                       i_cost,
    smcdp_res_if.source                      o_res
);
    import smcdp_pkg::*;

    // Frame counters and memory addresses hold 0..MAX_FRAMES.
    localparam int FRM_W   = $clog2(MAX_FRAMES + 1);
    // Start frames never reach MAX_FRAMES.
    localparam int START_W = $clog2(MAX_FRAMES);
    localparam int TGT_W   = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam int TCNT_W  = $clog2(MAX_TARGETS + 1);
    localparam int DEPTH   = MAX_FRAMES + 1;
    localparam logic [COST_BITS-1:0] INF = '1;

    // ------------------------------------------------------------------------
    // Configuration registers and their effective values
    // ------------------------------------------------------------------------
    logic [CFG_MIN_W-1:0] r_cfg_min;
    logic [CFG_SEQ_W-1:0] r_cfg_seq;
    logic [CFG_TGT_W-1:0] r_cfg_tgt;
    logic                 r_restart;
    logic                 cfg_hit;

    logic [FRM_W-1:0]  eff_min;
    logic [FRM_W-1:0]  seq_clamped;
    logic [FRM_W-1:0]  eff_seq;
    logic [TCNT_W-1:0] eff_tgt;

    // A zero register acts as one, and a large one is clipped to the size
    // of the storage. A sequence shorter than min_len runs one end frame.
    always_comb begin
        if (r_cfg_min == '0) begin
            eff_min = FRM_W'(1);
        end else if (32'(r_cfg_min) > 32'(MAX_FRAMES)) begin
            eff_min = FRM_W'(MAX_FRAMES);
        end else begin
            eff_min = FRM_W'(r_cfg_min);
        end

        if (r_cfg_seq == '0) begin
            seq_clamped = FRM_W'(1);
        end else if (32'(r_cfg_seq) > 32'(MAX_FRAMES)) begin
            seq_clamped = FRM_W'(MAX_FRAMES);
        end else begin
            seq_clamped = FRM_W'(r_cfg_seq);
        end
        eff_seq = (seq_clamped < eff_min) ? eff_min : seq_clamped;

        if (r_cfg_tgt == '0) begin
            eff_tgt = TCNT_W'(1);
        end else if (32'(r_cfg_tgt) > 32'(MAX_TARGETS)) begin
            eff_tgt = TCNT_W'(MAX_TARGETS);
        end else begin
            eff_tgt = TCNT_W'(r_cfg_tgt);
        end
    end

    assign cfg_hit = i_cfg_we && (i_cfg_idx == CFG_MIN_LEN || i_cfg_idx == CFG_SEQ_LEN ||
                                  i_cfg_idx == CFG_TARGET_COUNT);

    // ------------------------------------------------------------------------
    // Loop counters: end frame, target, start frame
    // ------------------------------------------------------------------------
    logic [FRM_W-1:0]   r_end;
    logic [TGT_W-1:0]   r_tgt;
    logic [START_W-1:0] r_start;

    logic [FRM_W-1:0] span;
    logic             start_last;
    logic             tgt_last;
    logic             frame_end;
    logic             run_last;
    logic             addr_zero;
    logic             addr_inf;
    logic             accept;

    assign span       = r_end - eff_min;
    assign start_last = (FRM_W'(r_start) == span);
    assign tgt_last   = ((TCNT_W'(r_tgt) + TCNT_W'(1)) == eff_tgt);
    assign frame_end  = start_last && tgt_last;
    assign run_last   = (r_end >= eff_seq);
    // Start zero always has a total of zero; starts below min_len have none.
    assign addr_zero  = (r_start == '0);
    assign addr_inf   = (FRM_W'(r_start) < eff_min);

    // ------------------------------------------------------------------------
    // Second stage: add, saturate and compare
    // ------------------------------------------------------------------------
    logic                 r_s1_valid;
    logic [COST_BITS-1:0] r_s1_cost;
    logic                 r_s1_zero;
    logic                 r_s1_inf;
    logic [TGT_W-1:0]     r_s1_tgt;
    logic [START_W-1:0]   r_s1_start;
    logic                 r_s1_fend;
    logic [FRM_W-1:0]     r_s1_frame;
    logic                 r_s1_last;
    logic [COST_BITS-1:0] r_rd_data;

    logic [COST_BITS-1:0] r_min;
    logic [TGT_W-1:0]     r_win_tgt;
    logic [START_W-1:0]   r_win_start;

    logic [COST_BITS-1:0] total;
    logic [COST_BITS:0]   sum;
    logic [COST_BITS-1:0] cand;
    logic                 better;
    logic [COST_BITS-1:0] n_min;
    logic [TGT_W-1:0]     n_win_tgt;
    logic [START_W-1:0]   n_win_start;

    logic r_out_valid;
    logic out_free;
    logic s1_fire;
    logic emit;

    always_comb begin
        if (r_s1_zero) begin
            total = '0;
        end else if (r_s1_inf) begin
            total = INF;
        end else begin
            total = r_rd_data;
        end
        sum    = {1'b0, total} + {1'b0, r_s1_cost};
        cand   = sum[COST_BITS] ? INF : sum[COST_BITS-1:0];
        // Strict compare: on a tie the earlier candidate stays.
        better = (cand < r_min);
        n_min       = better ? cand : r_min;
        n_win_tgt   = better ? r_s1_tgt : r_win_tgt;
        n_win_start = better ? r_s1_start : r_win_start;
    end

    assign out_free     = !r_out_valid || o_res.ready;
    assign s1_fire      = r_s1_valid && (!r_s1_fend || out_free);
    assign emit         = s1_fire && r_s1_fend;
    assign i_cost.ready = (!r_s1_valid || s1_fire) && !r_restart;
    assign accept       = i_cost.valid && i_cost.ready;

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_min   <= CFG_MIN_RST;
            r_cfg_seq   <= CFG_SEQ_RST;
            r_cfg_tgt   <= CFG_TGT_RST;
            r_restart   <= 1'b0;
            r_end       <= FRM_W'(1);
            r_tgt       <= '0;
            r_start     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_min       <= INF;
            r_win_tgt   <= '0;
            r_win_start <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_LEN:      r_cfg_min <= i_cfg_data[CFG_MIN_W-1:0];
                    CFG_SEQ_LEN:      r_cfg_seq <= i_cfg_data[CFG_SEQ_W-1:0];
                    CFG_TARGET_COUNT: r_cfg_tgt <= i_cfg_data[CFG_TGT_W-1:0];
                    default: begin
                    end
                endcase
            end
            // The counters reload in the cycle after a write, from the new values.
            r_restart <= cfg_hit;

            if (r_restart) begin
                r_end   <= eff_min;
                r_tgt   <= '0;
                r_start <= '0;
            end else if (accept) begin
                if (!start_last) begin
                    r_start <= r_start + START_W'(1);
                end else begin
                    r_start <= '0;
                    if (!tgt_last) begin
                        r_tgt <= r_tgt + TGT_W'(1);
                    end else begin
                        r_tgt <= '0;
                        r_end <= run_last ? eff_min : r_end + FRM_W'(1);
                    end
                end
            end

            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end

            if (cfg_hit || emit) begin
                r_min       <= INF;
                r_win_tgt   <= '0;
                r_win_start <= '0;
            end else if (s1_fire) begin
                r_min       <= n_min;
                r_win_tgt   <= n_win_tgt;
                r_win_start <= n_win_start;
            end

            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage payload
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cost  <= COST_BITS'(i_cost.seg_cost);
            r_s1_zero  <= addr_zero;
            r_s1_inf   <= addr_inf;
            r_s1_tgt   <= r_tgt;
            r_s1_start <= r_start;
            r_s1_fend  <= frame_end;
            r_s1_frame <= r_end;
            r_s1_last  <= run_last;
        end
    end

    // ------------------------------------------------------------------------
    // Total memory: one write port, one registered read port
    // ------------------------------------------------------------------------
    logic [COST_BITS-1:0] total_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (emit) begin
            total_mem[r_s1_frame] <= n_min;
        end
        if (accept) begin
            r_rd_data <= total_mem[FRM_W'(r_start)];
        end
    end

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    logic [END_W-1:0]       r_out_end;
    logic [TOTAL_W-1:0]     r_out_total;
    logic [TGT_OUT_W-1:0]   r_out_tgt;
    logic [START_OUT_W-1:0] r_out_start;
    logic                   r_out_last;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_end   <= END_W'(r_s1_frame);
            r_out_total <= TOTAL_W'(n_min);
            r_out_tgt   <= TGT_OUT_W'(n_win_tgt);
            r_out_start <= START_OUT_W'(n_win_start);
            r_out_last  <= r_s1_last;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.end_frame   = r_out_end;
    assign o_res.best_total  = r_out_total;
    assign o_res.best_target = r_out_tgt;
    assign o_res.best_start  = r_out_start;
    assign o_res.last        = r_out_last;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // A finished end frame always lands in the output register.
    a_emit_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> r_out_valid)
        else $error("finished end frame did not reach the output register");

    // A new output appears only when an end frame was finished.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(emit))
        else $error("output became valid without a finished end frame");

    // The running minimum starts over after every emitted end frame.
    a_min_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_min == INF))
        else $error("running minimum not cleared after an end frame");

    // The end frame counter stays inside the legal range of the run.
    a_end_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_restart |-> (r_end >= eff_min && r_end <= eff_seq))
        else $error("end frame counter out of range");

    // The start frame never passes the last start of the current end frame.
    a_start_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_restart |-> (FRM_W'(r_start) <= span))
        else $error("start frame counter out of range");

endmodule

`default_nettype wire

// ===== verif/smcdp_total_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// smcdp_total_checker
// Watches the cost, result and register ports of the segmentation block,
// predicts every finished end frame and compares each result field by field.
// ----------------------------------------------------------------------------

module smcdp_total_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [smcdp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [smcdp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    smcdp_cost_if                            i_cost,
    smcdp_res_if                             i_res,
    output int                               o_failures,
    output int                               o_pending
);
    import smcdp_pkg::*;

    typedef struct packed {
        logic [END_W-1:0]       end_frame;
        logic [TOTAL_W-1:0]     best_total;
        logic [TGT_OUT_W-1:0]   best_target;
        logic [START_OUT_W-1:0] best_start;
        logic                   last;
    } t_frame_result;

    // Best total of every finished end frame; frame zero is a constant zero.
    logic [TOTAL_W-1:0]     frame_totals [1:DEF_MAX_FRAMES];

    logic [CFG_MIN_W-1:0]   min_len_reg;
    logic [CFG_SEQ_W-1:0]   seq_len_reg;
    logic [CFG_TGT_W-1:0]   target_count_reg;

    logic [END_W-1:0]       end_ctr;
    logic [TGT_OUT_W-1:0]   target_ctr;
    logic [START_OUT_W-1:0] start_ctr;
    logic [COST_W-1:0]      running_min;
    logic [TGT_OUT_W-1:0]   win_target;
    logic [START_OUT_W-1:0] win_start;

    t_frame_result          finished_frames [$];

    function automatic logic [END_W-1:0] clamp_frames(input logic [CFG_MIN_W-1:0] v);
        if (v == '0) return END_W'(1);
        if (v > DEF_MAX_FRAMES) return END_W'(DEF_MAX_FRAMES);
        return v;
    endfunction

    function automatic logic [END_W-1:0] last_frame();
        logic [END_W-1:0] s;
        logic [END_W-1:0] m;
        s = clamp_frames(seq_len_reg);
        m = clamp_frames(min_len_reg);
        return (s < m) ? m : s;
    endfunction

    function automatic logic [CFG_TGT_W-1:0] targets_per_segment();
        if (target_count_reg == '0) return CFG_TGT_W'(1);
        if (target_count_reg > DEF_MAX_TARGETS) return CFG_TGT_W'(DEF_MAX_TARGETS);
        return target_count_reg;
    endfunction

    task automatic restart_run();
        end_ctr     = clamp_frames(min_len_reg);
        target_ctr  = '0;
        start_ctr   = '0;
        running_min = '1;
        win_target  = '0;
        win_start   = '0;
    endtask

    // Folds one cost into the running minimum and advances the counters in
    // stream order. A finished end frame is stored and queued as a result.
    task automatic absorb_cost(input logic [COST_W-1:0] cost);
        logic [END_W-1:0]     emin;
        logic [COST_W-1:0]    base;
        logic [COST_W:0]      sum;
        logic [COST_W-1:0]    cand;
        logic [CFG_TGT_W-1:0] next_target;
        t_frame_result        done;
        emin = clamp_frames(min_len_reg);
        if (start_ctr == '0)
            base = '0;
        else if ({1'b0, start_ctr} < emin)
            base = '1;
        else
            base = frame_totals[start_ctr];
        sum  = {1'b0, base} + {1'b0, cost};
        cand = sum[COST_W] ? '1 : sum[COST_W-1:0];
        if (cand < running_min) begin
            running_min = cand;
            win_target  = target_ctr;
            win_start   = start_ctr;
        end
        if ({1'b0, start_ctr} < end_ctr - emin) begin
            start_ctr = start_ctr + 1'b1;
        end else begin
            start_ctr   = '0;
            next_target = {1'b0, target_ctr} + 1'b1;
            if (next_target < targets_per_segment()) begin
                target_ctr = next_target[TGT_OUT_W-1:0];
            end else begin
                target_ctr = '0;
                frame_totals[end_ctr] = running_min;
                done.end_frame   = end_ctr;
                done.best_total  = running_min;
                done.best_target = win_target;
                done.best_start  = win_start;
                done.last        = (end_ctr >= last_frame());
                finished_frames.push_back(done);
                if (done.last) begin
                    restart_run();
                end else begin
                    end_ctr     = end_ctr + 1'b1;
                    running_min = '1;
                    win_target  = '0;
                    win_start   = '0;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_frame_result want;
        if (!i_rst_n) begin
            min_len_reg      = CFG_MIN_RST;
            seq_len_reg      = CFG_SEQ_RST;
            target_count_reg = CFG_TGT_RST;
            restart_run();
            finished_frames.delete();
            o_failures = 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_LEN: begin
                        min_len_reg = i_cfg_data[CFG_MIN_W-1:0];
                        restart_run();
                    end
                    CFG_SEQ_LEN: begin
                        seq_len_reg = i_cfg_data[CFG_SEQ_W-1:0];
                        restart_run();
                    end
                    CFG_TARGET_COUNT: begin
                        target_count_reg = i_cfg_data[CFG_TGT_W-1:0];
                        restart_run();
                    end
                    default: ;
                endcase
            end

            if (i_cost.valid && i_cost.ready)
                absorb_cost(i_cost.seg_cost);

            if (i_res.valid && i_res.ready) begin
                if (finished_frames.size() == 0) begin
                    $error("result for end_frame %0d arrived with none expected",
                           i_res.end_frame);
                    o_failures++;
                end else begin
                    want = finished_frames.pop_front();
                    if (i_res.end_frame !== want.end_frame) begin
                        $error("end_frame: expected %0d, got %0d",
                               want.end_frame, i_res.end_frame);
                        o_failures++;
                    end
                    if (i_res.best_total !== want.best_total) begin
                        $error("best_total: expected %h, got %h",
                               want.best_total, i_res.best_total);
                        o_failures++;
                    end
                    if (i_res.best_target !== want.best_target) begin
                        $error("best_target: expected %0d, got %0d",
                               want.best_target, i_res.best_target);
                        o_failures++;
                    end
                    if (i_res.best_start !== want.best_start) begin
                        $error("best_start: expected %0d, got %0d",
                               want.best_start, i_res.best_start);
                        o_failures++;
                    end
                    if (i_res.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, i_res.last);
                        o_failures++;
                    end
                end
            end
            o_pending <= finished_frames.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives segment costs and register settings into the segmentation block
// and gives the verdict; prediction and comparison live in the checker.
// ----------------------------------------------------------------------------

module tb;
    import smcdp_pkg::*;

    localparam int RANDOM_ITEMS = 240;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 300;
    localparam int TIMEOUT_NS   = 20_000_000;

    // Index past the register list; a write there must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    // Directed costs, in stream order, for three short slices. See the main
    // process for the configuration that goes with each slice.
    localparam logic [COST_W-1:0] DIRECTED_COSTS [21] = '{
        // Reset settings (min 1, tgt 1): first three end frames.
        32'h0000_0010,
        32'h0000_0030, 32'h0000_0010,
        32'h0000_0040, 32'h0000_0030, 32'h0000_0000,
        // min 1, seq 3, tgt 2.
        32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'h0000_0005, 32'h0000_0000, 32'h0000_0005, 32'h0000_0000,
        32'hFFFF_FFFE, 32'h0000_0000, 32'hFFFF_FFFC,
        32'h0001_0000, 32'h0000_0000, 32'h0000_0000,
        // min 2, seq 3, tgt 1.
        32'h0000_0007,
        32'h0000_0010, 32'h0000_0000
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    smcdp_cost_if cost_ch ();
    smcdp_res_if  res_ch ();

    int pending;
    int failures;

    // Register values as last written, masked to their width.
    int cur_min_len;
    int cur_seq_len;
    int cur_target_count;

    // Gap control shared between the main process and the two handshakes.
    int tx_burst;
    int rx_burst;
    int rx_hold;
    int random_items;

    segment_match_min_cost_dp dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cost     (cost_ch),
        .o_res      (res_ch)
    );

    smcdp_total_checker total_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cost     (cost_ch),
        .i_res      (res_ch),
        .o_failures (failures),
        .o_pending  (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Number of costs in one full run under the current settings. The block
    // treats zero as one and clamps large values, and a minimum length above
    // the sequence length gives a run of one end frame.
    function automatic int run_items();
        int em;
        int es;
        int et;
        int n;
        em = (cur_min_len == 0) ? 1 :
             (cur_min_len > DEF_MAX_FRAMES) ? DEF_MAX_FRAMES : cur_min_len;
        es = (cur_seq_len == 0) ? 1 :
             (cur_seq_len > DEF_MAX_FRAMES) ? DEF_MAX_FRAMES : cur_seq_len;
        if (es < em)
            es = em;
        et = (cur_target_count == 0) ? 1 :
             (cur_target_count > DEF_MAX_TARGETS) ? DEF_MAX_TARGETS : cur_target_count;
        n = es - em + 1;
        return et * n * (n + 1) / 2;
    endfunction

    // Costs are drawn from a few classes: small values that tie often,
    // zero, infinity, values that saturate when added to a total, and the
    // full 32-bit range so that every bit toggles.
    function automatic logic [COST_W-1:0] pick_cost();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom_range(0, 3) << 16;
            4:       return 32'hF000_0000 | $urandom;
            5, 6:    return $urandom_range(0, 32'h0003_FFFF);
            default: return $urandom;
        endcase
    endfunction

    // Called on a clock edge. Returning once the enable is low again keeps each
    // control signal at one update per time step when writes follow each other.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_MIN_LEN)
            cur_min_len = value & ((1 << CFG_MIN_W) - 1);
        else if (idx == CFG_SEQ_LEN)
            cur_seq_len = value & ((1 << CFG_SEQ_W) - 1);
        else if (idx == CFG_TARGET_COUNT)
            cur_target_count = value & ((1 << CFG_TGT_W) - 1);
    endtask

    task automatic configure(input int min_len, input int seq_len, input int targets);
        write_reg(CFG_MIN_LEN, min_len);
        write_reg(CFG_SEQ_LEN, seq_len);
        write_reg(CFG_TARGET_COUNT, targets);
    endtask

    // Offers one cost after a drawn gap and returns on the edge that takes
    // it. Valid stays high on return, so a following item with no gap keeps
    // it high without a second update in the same step.
    task automatic send_cost(input logic [COST_W-1:0] cost);
        int gap;
        if (tx_burst > 0) begin
            tx_burst--;
            gap = 0;
        end else if ($urandom_range(0, 39) == 0) begin
            tx_burst = $urandom_range(10, 60);
            gap = 0;
        end else begin
            gap = $urandom_range(0, 19);
        end
        if (gap > 0) begin
            cost_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cost_ch.valid    <= 1'b1;
        cost_ch.seg_cost <= cost;
        do @(posedge i_clk); while (!cost_ch.ready);
    endtask

    task automatic send_costs(input int count);
        repeat (count) send_cost(pick_cost());
    endtask

    // Stops offering and waits until every predicted frame has been taken.
    // The pending count is updated on the clock edge, so it is read after the
    // edge that sets it. The extra cycles cover a cost still in the pipeline
    // that closes no frame, so a register write that follows finds the block idle.
    task automatic settle();
        cost_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Result side: a drawn gap with ready low before each item, bursts with
    // ready held high, and on request one long hold so that the output
    // register fills and the block has to stall its cost input.
    initial begin
        int gap;
        res_ch.ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                gap = rx_hold;
                rx_hold = 0;
            end else if (rx_burst > 0) begin
                rx_burst--;
                gap = 0;
            end else if ($urandom_range(0, 39) == 0) begin
                rx_burst = $urandom_range(10, 60);
                gap = 0;
            end else begin
                gap = $urandom_range(0, 19);
            end
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    initial begin
        int min_len;
        int seq_len;
        int targets;
        int total;
        tx_burst         = 0;
        rx_burst         = 0;
        rx_hold          = 0;
        random_items     = 0;
        cur_min_len      = CFG_MIN_RST;
        cur_seq_len      = CFG_SEQ_RST;
        cur_target_count = CFG_TGT_RST;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= CFG_MIN_LEN;
        i_cfg_data       <= '0;
        cost_ch.valid    <= 1'b0;
        cost_ch.seg_cost <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: the first three end frames of the long default run.
        // Frame two is won from start one and frame three from start two,
        // with a tie on the way that the earlier start must keep.
        for (int i = 0; i < 6; i++)
            send_cost(DIRECTED_COSTS[i]);
        settle();

        // Two targets over three frames. Frame one sees only infinite costs
        // and so has no winner. Frame two ties across targets. Frame three
        // has a sum that saturates and is won by the second target.
        configure(1, 3, 2);
        for (int i = 6; i < 18; i++)
            send_cost(DIRECTED_COSTS[i]);
        settle();

        // Minimum length two: start one lies below it and reads as infinity.
        configure(2, 3, 1);
        for (int i = 18; i < 21; i++)
            send_cost(DIRECTED_COSTS[i]);
        settle();

        // Zero in every register acts as one: each run is a single cost.
        configure(0, 0, 0);
        send_costs(3 * run_items());
        settle();

        // Minimum length above the sequence length: one frame per run.
        configure(5, 3, 3);
        send_costs(2 * run_items());
        settle();

        // All data bits set in both length registers: both clamp to the
        // frame limit, so one run is the top frame with a single start for
        // each of three targets.
        configure(32'h1FFF, 32'h1FFF, 3);
        send_costs(run_items());
        settle();

        // End frames near the top of the store.
        configure(1000, 1006, 2);
        send_costs(run_items());
        settle();

        // The receiver holds off for a long stretch while costs keep coming
        // back to back, so the output register fills and the block stalls its input.
        configure(1, 6, 1);
        tx_burst = 1000;
        rx_hold  = LONG_HOLD;
        send_costs(run_items());
        tx_burst = 0;
        settle();

        // A write past the register list in the middle of a run must not
        // restart it: the rest of the run continues from frame three.
        configure(1, 5, 2);
        send_costs(6);
        settle();
        write_reg(CFG_IDX_SPARE, $urandom);
        send_costs(run_items() - 6);
        settle();

        // Random settings, mostly short runs with random costs. Some phases
        // break off in the middle of a run, which the next write restarts.
        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: begin
                    min_len = $urandom_range(1000, 1030);
                    seq_len = min_len + $urandom_range(0, 5);
                    targets = $urandom_range(1, 3);
                end
                1: begin
                    min_len = $urandom_range(1, 3);
                    seq_len = min_len;
                    targets = $urandom_range(5, 60);
                end
                default: begin
                    min_len = $urandom_range(1, 4);
                    seq_len = $urandom_range(1, min_len + 6);
                    targets = $urandom_range(1, 4);
                end
            endcase
            // Bits above the length registers are dropped by the block.
            if ($urandom_range(0, 3) == 0)
                min_len = min_len | ($urandom_range(0, 3) << CFG_MIN_W);
            if ($urandom_range(0, 3) == 0)
                seq_len = seq_len | ($urandom_range(0, 3) << CFG_SEQ_W);
            configure(min_len, seq_len, targets);
            total = $urandom_range(1, 3) * run_items();
            if ($urandom_range(0, 5) == 0)
                total = $urandom_range(1, total);
            send_costs(total);
            random_items += total;
            settle();
        end

        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/smcdp_pkg.sv
hw/rtl/smcdp_cost_if.sv
hw/rtl/smcdp_res_if.sv
hw/rtl/segment_match_min_cost_dp.sv
verif/smcdp_total_checker.sv
verif/tb.sv
